>>> src/ljw_pkg.sv
// shared types, constants and arithmetic helpers for the lennard-jones wall block
// no dependencies
package ljw_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_EXPONENT = 15;
    localparam int D_W          = 32;
    localparam int Q_W          = D_W - 1;
    localparam int EXP_W        = $clog2(MAX_EXPONENT + 1);
    localparam int REG_EXP_W    = 4;
    localparam int R_NUM_W      = Q_W + FRAC_BITS;
    localparam int T_NUM_W      = Q_W + EXP_W + FRAC_BITS;
    localparam int DIV_LAT      = Q_W + 1;
    localparam int POW_LAT      = MAX_EXPONENT;
    localparam int PROD_W       = 2 * D_W;
    localparam int WIDE_W       = PROD_W - FRAC_BITS + 1;
    localparam int ADDR_W       = 5;

    localparam logic [Q_W-1:0] Q_MAX = '1;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(64'd1 << FRAC_BITS);
    localparam logic signed [D_W-1:0] S_MAX = {1'b0, {Q_W{1'b1}}};
    localparam logic signed [D_W-1:0] S_MIN = {1'b1, {Q_W{1'b0}}};

    localparam logic [D_W-1:0]       RST_WALL_LOW  = 32'd0;
    localparam logic [D_W-1:0]       RST_WALL_HIGH = 32'd655360;
    localparam logic [D_W-1:0]       RST_GAIN      = 32'd65536;
    localparam logic [Q_W-1:0]       RST_SIGMA     = 31'd65536;
    localparam logic [REG_EXP_W-1:0] RST_REPULSE   = 4'd12;
    localparam logic [REG_EXP_W-1:0] RST_ATTRACT   = 4'd6;
    localparam logic [D_W-1:0]       RST_STEP      = 32'd65536;
    localparam logic [D_W-1:0]       RST_COUPLING  = 32'd0;

    typedef enum logic [2:0] {
        REG_WALL_LOW,
        REG_WALL_HIGH,
        REG_FORCE_GAIN,
        REG_SIGMA_LEN,
        REG_REPULSE_EXP,
        REG_ATTRACT_EXP,
        REG_STEP_SCALE,
        REG_COUPLING
    } reg_idx_t;

    typedef struct packed {
        logic                  cmd;
        logic signed [D_W-1:0] x_pos;
        logic signed [D_W-1:0] y_pos;
    } item_t;

    typedef struct packed {
        logic signed [D_W-1:0] new_x;
        logic signed [D_W-1:0] new_y;
        logic                  saturated;
    } result_t;

    typedef struct packed {
        logic signed [D_W-1:0] wall_low_pos;
        logic signed [D_W-1:0] wall_high_pos;
        logic signed [D_W-1:0] force_gain;
        logic [Q_W-1:0]        sigma_len;
        logic [REG_EXP_W-1:0]  repulse_exp;
        logic [REG_EXP_W-1:0]  attract_exp;
        logic signed [D_W-1:0] step_scale;
        logic signed [D_W-1:0] coupling;
    } cfg_t;

    typedef struct packed {
        logic [Q_W-1:0] d;
        logic           ovf;
    } dist_t;

    typedef struct packed {
        logic signed [D_W-1:0] v;
        logic                  ovf;
    } sat_t;

    typedef struct packed {
        logic                  cmd;
        logic signed [D_W-1:0] x;
        logic signed [D_W-1:0] y;
        logic [Q_W-1:0]        d0;
        logic [Q_W-1:0]        d1;
        logic                  z0;
        logic                  z1;
        logic                  flag;
    } side_t;

    typedef struct packed {
        logic                  cmd;
        logic signed [D_W-1:0] x;
        logic signed [D_W-1:0] y;
        logic                  flag;
    } tail_t;

    function automatic logic [EXP_W-1:0] clamp_exp(input logic [REG_EXP_W-1:0] e);
        if (int'(e) > MAX_EXPONENT)
        begin
            return EXP_W'(MAX_EXPONENT);
        end
        return EXP_W'(e);
    endfunction

    function automatic dist_t dist_calc(input logic signed [D_W-1:0] x,
                                        input logic signed [D_W-1:0] w);
        dist_t             r;
        logic signed [D_W:0] dv;
        logic [D_W:0]      av;
        dv    = {x[D_W-1], x} - {w[D_W-1], w};
        av    = dv[D_W] ? -dv : dv;
        r.ovf = |av[D_W:Q_W];
        r.d   = r.ovf ? Q_MAX : av[Q_W-1:0];
        return r;
    endfunction

    function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        r.ovf = !((&v[WIDE_W-1:D_W-1]) || !(|v[WIDE_W-1:D_W-1]));
        r.v   = r.ovf ? (v[WIDE_W-1] ? S_MIN : S_MAX) : v[D_W-1:0];
        return r;
    endfunction

    function automatic logic signed [WIDE_W-1:0] shr_prod(input logic signed [PROD_W-1:0] p);
        return WIDE_W'($signed(p[PROD_W-1:FRAC_BITS]));
    endfunction

    function automatic logic signed [WIDE_W-1:0] ext_wide(input logic signed [D_W-1:0] v);
        return WIDE_W'(v);
    endfunction

    // bracket term for one wall, zero distance handled by exponent order
    function automatic sat_t wall_diff(input logic [Q_W-1:0] tm, input logic [Q_W-1:0] tn,
                                       input logic fm, input logic fn, input logic z,
                                       input logic [EXP_W-1:0] m, input logic [EXP_W-1:0] n);
        sat_t           r;
        logic [Q_W-1:0] um;
        logic [Q_W-1:0] un;
        um = (m == '0) ? '0 : tm;
        un = (n == '0) ? '0 : tn;
        if (z)
        begin
            r.ovf = 1'b1;
            r.v   = (m > n) ? S_MAX : ((m < n) ? S_MIN : '0);
        end
        else
        begin
            r.ovf = ((m != '0) && fm) || ((n != '0) && fn);
            r.v   = $signed({1'b0, um}) - $signed({1'b0, un});
        end
        return r;
    endfunction

endpackage

>>> src/lj_wall_displacement.sv
// top level of the lennard-jones wall displacement pipeline
// depends on ljw_pkg, ljw_cfg, ljw_div, ljw_pow, ljw_delay
//
//   channel   handshake              payload           transfer at
//   input     start / busy           item (item_t)     start high, busy low
//   result    done (strobe)          result (result_t) every cycle done is high
//   config    psel penable pwrite    paddr pwdata      access phase, pready high
//
// one item per cycle, busy stays low
// pipeline depth is set by the two rounds of restoring dividers (32 stages each, one quotient bit per stage)
// and the power chain (15 stages, one 31x31 multiply per stage)
// reset clears all valid bits and loads register defaults
// the receiver takes every result as it appears, so nothing ever stalls
module lj_wall_displacement
    import ljw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [D_W-1:0]    pwdata,
    output logic [D_W-1:0]    prdata,
    output logic              pready
);

    localparam int SIDE_W = $bits(side_t);

    cfg_t           cfg;
    logic [EXP_W-1:0] mc;
    logic [EXP_W-1:0] nc;

    ljw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign mc     = clamp_exp(cfg.repulse_exp);
    assign nc     = clamp_exp(cfg.attract_exp);

    // distance stage
    dist_t dist0;
    dist_t dist1;
    logic  a_vld_reg;
    side_t a_side_reg;

    assign dist0 = dist_calc(item.x_pos, cfg.wall_low_pos);
    assign dist1 = dist_calc(item.x_pos, cfg.wall_high_pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg.cmd  <= item.cmd;
        a_side_reg.x    <= item.x_pos;
        a_side_reg.y    <= item.y_pos;
        a_side_reg.d0   <= dist0.d;
        a_side_reg.d1   <= dist1.d;
        a_side_reg.z0   <= (dist0.d == '0);
        a_side_reg.z1   <= (dist1.d == '0);
        a_side_reg.flag <= dist0.ovf | dist1.ovf;
    end

    // sigma over distance
    logic [Q_W-1:0] r0;
    logic [Q_W-1:0] r1;
    logic           r0_ovf;
    logic           r1_ovf;
    logic           b_vld;
    side_t          b_side;

    ljw_div #(.NUM_W(R_NUM_W)) u_div_r0 (
        .clk (clk),
        .num ({cfg.sigma_len, {FRAC_BITS{1'b0}}}),
        .den (a_side_reg.d0),
        .quo (r0),
        .ovf (r0_ovf)
    );

    ljw_div #(.NUM_W(R_NUM_W)) u_div_r1 (
        .clk (clk),
        .num ({cfg.sigma_len, {FRAC_BITS{1'b0}}}),
        .den (a_side_reg.d1),
        .quo (r1),
        .ovf (r1_ovf)
    );

    ljw_delay #(.WIDTH(SIDE_W + 1), .DEPTH(DIV_LAT)) u_dly_b (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({a_vld_reg, a_side_reg}),
        .q     ({b_vld, b_side})
    );

    // powers of sigma over distance
    logic [Q_W-1:0] pm0;
    logic [Q_W-1:0] pn0;
    logic [Q_W-1:0] pm1;
    logic [Q_W-1:0] pn1;
    logic           fm0;
    logic           fn0;
    logic           fm1;
    logic           fn1;
    logic           c_vld;
    side_t          c_side;

    ljw_pow u_pow0 (
        .clk   (clk),
        .r     (r0),
        .r_ovf (r0_ovf),
        .m_exp (mc),
        .n_exp (nc),
        .pm    (pm0),
        .pn    (pn0),
        .fm    (fm0),
        .fn    (fn0)
    );

    ljw_pow u_pow1 (
        .clk   (clk),
        .r     (r1),
        .r_ovf (r1_ovf),
        .m_exp (mc),
        .n_exp (nc),
        .pm    (pm1),
        .pn    (pn1),
        .fm    (fm1),
        .fn    (fn1)
    );

    ljw_delay #(.WIDTH(SIDE_W + 1), .DEPTH(POW_LAT)) u_dly_c (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({b_vld, b_side}),
        .q     ({c_vld, c_side})
    );

    // terms k * p / d
    logic [EXP_W+Q_W-1:0] km0;
    logic [EXP_W+Q_W-1:0] kn0;
    logic [EXP_W+Q_W-1:0] km1;
    logic [EXP_W+Q_W-1:0] kn1;
    logic [Q_W-1:0]       tm0;
    logic [Q_W-1:0]       tn0;
    logic [Q_W-1:0]       tm1;
    logic [Q_W-1:0]       tn1;
    logic                 om0;
    logic                 on0;
    logic                 om1;
    logic                 on1;
    logic                 e_vld;
    side_t                e_side;
    logic [3:0]           e_pf;

    assign km0 = mc * pm0;
    assign kn0 = nc * pn0;
    assign km1 = mc * pm1;
    assign kn1 = nc * pn1;

    ljw_div #(.NUM_W(T_NUM_W)) u_div_m0 (
        .clk (clk),
        .num ({km0, {FRAC_BITS{1'b0}}}),
        .den (c_side.d0),
        .quo (tm0),
        .ovf (om0)
    );

    ljw_div #(.NUM_W(T_NUM_W)) u_div_n0 (
        .clk (clk),
        .num ({kn0, {FRAC_BITS{1'b0}}}),
        .den (c_side.d0),
        .quo (tn0),
        .ovf (on0)
    );

    ljw_div #(.NUM_W(T_NUM_W)) u_div_m1 (
        .clk (clk),
        .num ({km1, {FRAC_BITS{1'b0}}}),
        .den (c_side.d1),
        .quo (tm1),
        .ovf (om1)
    );

    ljw_div #(.NUM_W(T_NUM_W)) u_div_n1 (
        .clk (clk),
        .num ({kn1, {FRAC_BITS{1'b0}}}),
        .den (c_side.d1),
        .quo (tn1),
        .ovf (on1)
    );

    ljw_delay #(.WIDTH(SIDE_W + 5), .DEPTH(DIV_LAT)) u_dly_e (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({c_vld, c_side, fm0, fn0, fm1, fn1}),
        .q     ({e_vld, e_side, e_pf})
    );

    // force and displacement stages
    sat_t diff0;
    sat_t diff1;
    sat_t f0;
    sat_t ff;
    sat_t net;
    sat_t disp;
    sat_t nx;
    sat_t dy;
    sat_t ny;

    assign diff0 = wall_diff(tm0, tn0, e_pf[3] | om0, e_pf[2] | on0, e_side.z0, mc, nc);
    assign diff1 = wall_diff(tm1, tn1, e_pf[1] | om1, e_pf[0] | on1, e_side.z1, mc, nc);

    logic                     p1_vld_reg;
    logic                     p2_vld_reg;
    logic                     p3_vld_reg;
    logic                     p4_vld_reg;
    logic                     p5_vld_reg;
    logic                     p6_vld_reg;
    logic                     done_reg;
    tail_t                    p1_tail_reg;
    tail_t                    p2_tail_reg;
    tail_t                    p3_tail_reg;
    tail_t                    p4_tail_reg;
    tail_t                    p5_tail_reg;
    tail_t                    p6_tail_reg;
    logic signed [D_W-1:0]    p1_diff0_reg;
    logic signed [D_W-1:0]    p1_diff1_reg;
    logic signed [PROD_W-1:0] p2_prod0_reg;
    logic signed [PROD_W-1:0] p2_prod1_reg;
    logic signed [D_W-1:0]    p3_net_reg;
    logic signed [PROD_W-1:0] p4_prod_reg;
    logic signed [D_W-1:0]    p5_disp_reg;
    logic signed [D_W-1:0]    p5_nx_reg;
    logic signed [PROD_W-1:0] p6_prod_reg;
    logic signed [D_W-1:0]    p6_nx_reg;
    result_t                  result_reg;

    assign f0   = sat_wide(shr_prod(p2_prod0_reg));
    assign ff   = sat_wide(-shr_prod(p2_prod1_reg));
    assign net  = sat_wide(ext_wide(f0.v) + ext_wide(ff.v));
    assign disp = sat_wide(shr_prod(p4_prod_reg));
    assign nx   = sat_wide(ext_wide(p4_tail_reg.x) + ext_wide(disp.v));
    assign dy   = sat_wide(shr_prod(p6_prod_reg));
    assign ny   = sat_wide(ext_wide(p6_tail_reg.y) + ext_wide(dy.v));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= e_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
            done_reg   <= p6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_tail_reg.cmd  <= e_side.cmd;
        p1_tail_reg.x    <= e_side.x;
        p1_tail_reg.y    <= e_side.y;
        p1_tail_reg.flag <= e_side.flag | diff0.ovf | diff1.ovf;
        p1_diff0_reg     <= diff0.v;
        p1_diff1_reg     <= diff1.v;

        p2_tail_reg  <= p1_tail_reg;
        p2_prod0_reg <= $signed(cfg.force_gain) * $signed(p1_diff0_reg);
        p2_prod1_reg <= $signed(cfg.force_gain) * $signed(p1_diff1_reg);

        p3_tail_reg.cmd  <= p2_tail_reg.cmd;
        p3_tail_reg.x    <= p2_tail_reg.x;
        p3_tail_reg.y    <= p2_tail_reg.y;
        p3_tail_reg.flag <= p2_tail_reg.flag | f0.ovf | ff.ovf | net.ovf;
        p3_net_reg       <= net.v;

        p4_tail_reg <= p3_tail_reg;
        p4_prod_reg <= $signed(p3_net_reg) * $signed(cfg.step_scale);

        p5_tail_reg.cmd  <= p4_tail_reg.cmd;
        p5_tail_reg.x    <= p4_tail_reg.x;
        p5_tail_reg.y    <= p4_tail_reg.y;
        p5_tail_reg.flag <= p4_tail_reg.flag | disp.ovf | nx.ovf;
        p5_disp_reg      <= disp.v;
        p5_nx_reg        <= nx.v;

        p6_tail_reg <= p5_tail_reg;
        p6_nx_reg   <= p5_nx_reg;
        p6_prod_reg <= $signed(p5_disp_reg) * $signed(cfg.coupling);

        result_reg.new_x <= p6_nx_reg;
        if (p6_tail_reg.cmd)
        begin
            result_reg.new_y     <= ny.v;
            result_reg.saturated <= p6_tail_reg.flag | dy.ovf | ny.ovf;
        end
        else
        begin
            result_reg.new_y     <= p6_tail_reg.y;
            result_reg.saturated <= p6_tail_reg.flag;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/ljw_delay.sv
// fixed-length shift line for side data and valid bits
// depends on nothing
module ljw_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] sh_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                sh_reg[i] <= '0;
            end
        end
        else
        begin
            sh_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                sh_reg[i] <= sh_reg[i-1];
            end
        end
    end

    assign q = sh_reg[DEPTH-1];

endmodule

>>> src/ljw_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
// depends on ljw_pkg
module ljw_div
    import ljw_pkg::*;
#(
    parameter int NUM_W = 47
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [Q_W-1:0]   den,
    output logic [Q_W-1:0]   quo,
    output logic             ovf
);

    localparam int HI_W = NUM_W - Q_W;

    logic [Q_W-1:0] rem_reg [0:Q_W-1];
    logic [Q_W-1:0] lo_reg  [0:Q_W-1];
    logic [Q_W-1:0] den_reg [0:Q_W-1];
    logic [Q_W-1:0] q_reg   [0:Q_W];
    logic           ovf_reg [0:Q_W];

    logic [HI_W-1:0] hi;
    logic            hi_ovf;

    assign hi     = num[NUM_W-1:Q_W];
    assign hi_ovf = {{(Q_W-HI_W){1'b0}}, hi} >= den;

    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= hi_ovf;
        rem_reg[0] <= hi_ovf ? '0 : Q_W'(hi);
        lo_reg[0]  <= num[Q_W-1:0];
        den_reg[0] <= den;
        q_reg[0]   <= '0;
    end

    for (genvar j = 1; j <= Q_W; j++)
    begin : g_stage
        logic [Q_W:0] trial;
        logic [Q_W:0] sub;
        logic         ge;

        assign trial = {rem_reg[j-1], lo_reg[j-1][Q_W-1]};
        assign sub   = trial - {1'b0, den_reg[j-1]};
        assign ge    = trial >= {1'b0, den_reg[j-1]};

        always_ff @(posedge clk)
        begin
            q_reg[j]   <= {q_reg[j-1][Q_W-2:0], ge};
            ovf_reg[j] <= ovf_reg[j-1];
        end

        if (j < Q_W)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= ge ? sub[Q_W-1:0] : trial[Q_W-1:0];
                lo_reg[j]  <= {lo_reg[j-1][Q_W-2:0], 1'b0};
                den_reg[j] <= den_reg[j-1];
            end
        end
    end

    assign quo = ovf_reg[Q_W] ? Q_MAX : q_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule

>>> src/ljw_pow.sv
// power chain, one saturating fixed-point multiply per stage, taps at both exponents
// depends on ljw_pkg
module ljw_pow
    import ljw_pkg::*;
(
    input  logic             clk,
    input  logic [Q_W-1:0]   r,
    input  logic             r_ovf,
    input  logic [EXP_W-1:0] m_exp,
    input  logic [EXP_W-1:0] n_exp,
    output logic [Q_W-1:0]   pm,
    output logic [Q_W-1:0]   pn,
    output logic             fm,
    output logic             fn
);

    typedef struct packed {
        logic [Q_W-1:0] p;
        logic [Q_W-1:0] r;
        logic [Q_W-1:0] pm;
        logic [Q_W-1:0] pn;
        logic           fm;
        logic           fn;
    } pow_st_t;

    pow_st_t st0;
    pow_st_t st_reg [1:MAX_EXPONENT];

    assign st0 = '{p: Q_ONE, r: r, pm: Q_ONE, pn: Q_ONE, fm: r_ovf, fn: r_ovf};

    for (genvar i = 1; i <= MAX_EXPONENT; i++)
    begin : g_stage
        pow_st_t                        prv;
        logic [2*Q_W-1:0]               prod;
        logic [2*Q_W-FRAC_BITS-1:0]     sh;
        logic                           ov;
        logic [Q_W-1:0]                 pv;

        if (i == 1)
        begin : g_first
            assign prv = st0;
        end
        else
        begin : g_next
            assign prv = st_reg[i-1];
        end

        assign prod = prv.p * prv.r;
        assign sh   = prod[2*Q_W-1:FRAC_BITS];
        assign ov   = |sh[2*Q_W-FRAC_BITS-1:Q_W];
        assign pv   = ov ? Q_MAX : sh[Q_W-1:0];

        always_ff @(posedge clk)
        begin
            st_reg[i].p  <= pv;
            st_reg[i].r  <= prv.r;
            st_reg[i].pm <= (m_exp >= EXP_W'(i)) ? pv : prv.pm;
            st_reg[i].pn <= (n_exp >= EXP_W'(i)) ? pv : prv.pn;
            st_reg[i].fm <= prv.fm | ((m_exp >= EXP_W'(i)) & ov);
            st_reg[i].fn <= prv.fn | ((n_exp >= EXP_W'(i)) & ov);
        end
    end

    assign pm = st_reg[MAX_EXPONENT].pm;
    assign pn = st_reg[MAX_EXPONENT].pn;
    assign fm = st_reg[MAX_EXPONENT].fm;
    assign fn = st_reg[MAX_EXPONENT].fn;

endmodule

>>> src/ljw_cfg.sv
// configuration register file behind the apb-style port
// depends on ljw_pkg
module ljw_cfg
    import ljw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [D_W-1:0]    pwdata,
    output logic [D_W-1:0]    prdata,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wall_low_pos  <= RST_WALL_LOW;
            cfg_reg.wall_high_pos <= RST_WALL_HIGH;
            cfg_reg.force_gain    <= RST_GAIN;
            cfg_reg.sigma_len     <= RST_SIGMA;
            cfg_reg.repulse_exp   <= RST_REPULSE;
            cfg_reg.attract_exp   <= RST_ATTRACT;
            cfg_reg.step_scale    <= RST_STEP;
            cfg_reg.coupling      <= RST_COUPLING;
        end
        else if (wr)
        begin
            case (idx)
                REG_WALL_LOW:    cfg_reg.wall_low_pos  <= pwdata;
                REG_WALL_HIGH:   cfg_reg.wall_high_pos <= pwdata;
                REG_FORCE_GAIN:  cfg_reg.force_gain    <= pwdata;
                REG_SIGMA_LEN:   cfg_reg.sigma_len     <= pwdata[Q_W-1:0];
                REG_REPULSE_EXP: cfg_reg.repulse_exp   <= pwdata[REG_EXP_W-1:0];
                REG_ATTRACT_EXP: cfg_reg.attract_exp   <= pwdata[REG_EXP_W-1:0];
                REG_STEP_SCALE:  cfg_reg.step_scale    <= pwdata;
                REG_COUPLING:    cfg_reg.coupling      <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WALL_LOW:    prdata = cfg_reg.wall_low_pos;
            REG_WALL_HIGH:   prdata = cfg_reg.wall_high_pos;
            REG_FORCE_GAIN:  prdata = cfg_reg.force_gain;
            REG_SIGMA_LEN:   prdata = D_W'(cfg_reg.sigma_len);
            REG_REPULSE_EXP: prdata = D_W'(cfg_reg.repulse_exp);
            REG_ATTRACT_EXP: prdata = D_W'(cfg_reg.attract_exp);
            REG_STEP_SCALE:  prdata = cfg_reg.step_scale;
            REG_COUPLING:    prdata = cfg_reg.coupling;
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
